[src/hcit_pkg.sv]
package hcit_pkg;

   // Id space: ids run from 1 to ID_LIMIT, 0 marks an empty slot
   localparam int ID_W = 10;
   localparam int ID_COUNT = 1024;
   localparam logic [ID_W-1:0] ID_LIMIT = 10'd1023;

   // Input item layout
   localparam int WORD_W = 32;
   localparam int IN_KEY_FIELDS = 6;

   // Parameter defaults
   localparam int SLOT_COUNT_DEF = 1024;
   localparam int KEY_WORDS_DEF = 6;

   // Hash constants
   localparam logic [63:0] HASH_SEED = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
   localparam int MIX_SHIFT1 = 30;
   localparam int MIX_SHIFT2 = 27;
   localparam int MIX_SHIFT3 = 31;

   // Load limit: (count + 1) * LOAD_DEN >= slots * LOAD_NUM
   localparam int LOAD_NUM = 7;
   localparam int LOAD_DEN = 10;

   // Command codes
   localparam logic CMD_INTERN = 1'b0;
   localparam logic CMD_ROLLBACK = 1'b1;

   // Result status codes
   typedef enum logic [2:0] {
      STS_FOUND    = 3'd0,
      STS_INSERTED = 3'd1,
      STS_LIMIT    = 3'd2,
      STS_FULL     = 3'd3,
      STS_REFUSED  = 3'd4,
      STS_ROLLBACK = 3'd5
   } status_type;

endpackage

[src/hcit_ram.sv]
module hcit_ram
   #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
   )
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/hcit_hash.sv]
module hcit_hash
   import hcit_pkg::*;
   #(
   parameter int KEY_WORDS = KEY_WORDS_DEF,
   parameter int SLOT_BITS = 10,
   localparam int WW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1
   )
   (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_W-1:0]    word,
   output logic [WW-1:0]        word_idx,
   output logic                 done,
   output logic [SLOT_BITS-1:0] home
   );

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_XOR,
      HS_M0,
      HS_M1,
      HS_M2,
      HS_X27,
      HS_X31
   } hstate_type;

   hstate_type  state_ff, state_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] acc_ff, acc_in;
   logic [WW-1:0] widx_ff, widx_in;
   logic        second_ff, second_in;
   logic        done_ff, done_in;

   logic [63:0] mul_const;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [63:0] prod;
   logic [63:0] xin;

   // One 32x32 multiplier, three partial products per 64-bit multiply (low half kept)
   always_comb begin
      mul_const = second_ff ? MIX_MUL2 : MIX_MUL1;
      op_a = (state_ff == HS_M2) ? v_ff[63:32] : v_ff[31:0];
      op_b = (state_ff == HS_M1) ? mul_const[63:32] : mul_const[31:0];
      prod = {32'b0, op_a} * {32'b0, op_b};
      xin = h_ff ^ {32'b0, word};
   end

   // Round sequencer
   always_comb begin
      state_in = state_ff;
      h_in = h_ff;
      v_in = v_ff;
      acc_in = acc_ff;
      widx_in = widx_ff;
      second_in = second_ff;
      done_in = 1'b0;
      unique case (state_ff)
         HS_IDLE: begin
            if (start) begin
               h_in = HASH_SEED;
               widx_in = '0;
               state_in = HS_XOR;
            end
         end
         HS_XOR: begin
            v_in = xin ^ (xin >> MIX_SHIFT1);
            second_in = 1'b0;
            state_in = HS_M0;
         end
         HS_M0: begin
            acc_in = prod;
            state_in = HS_M1;
         end
         HS_M1: begin
            acc_in = acc_ff + {prod[31:0], 32'b0};
            state_in = HS_M2;
         end
         HS_M2: begin
            acc_in = acc_ff + {prod[31:0], 32'b0};
            state_in = second_ff ? HS_X31 : HS_X27;
         end
         HS_X27: begin
            v_in = acc_ff ^ (acc_ff >> MIX_SHIFT2);
            second_in = 1'b1;
            state_in = HS_M0;
         end
         HS_X31: begin
            h_in = acc_ff ^ (acc_ff >> MIX_SHIFT3);
            if (widx_ff == WW'(KEY_WORDS - 1)) begin
               done_in = 1'b1;
               state_in = HS_IDLE;
            end else begin
               widx_in = widx_ff + 1'b1;
               state_in = HS_XOR;
            end
         end
         default: state_in = HS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      h_ff <= h_in;
      v_ff <= v_in;
      acc_ff <= acc_in;
      widx_ff <= widx_in;
      second_ff <= second_in;
   end

   assign word_idx = widx_ff;
   assign done = done_ff;
   assign home = h_ff[SLOT_BITS-1:0];

endmodule

[src/hash_consing_intern_table_unit.sv]
// Intern: hash the key word by word (one shared 32x32 multiplier), then probe slots
// onward from the home slot, comparing the stored key word by word on each home match,
// and store a new key word by word. Rollback: per removed id, reload its key, hash it,
// find its slot and walk on, shifting entries back. One item at a time; a result is a
// one-cycle strobe. Synchronous reset; after reset a sweep zeroes every slot of the slot
// table with busy high. The receiver cannot stall.
module hash_consing_intern_table_unit
   import hcit_pkg::*;
   #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int KEY_WORDS = KEY_WORDS_DEF
   )
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [WORD_W-1:0] req_key_word0,
   input  logic [WORD_W-1:0] req_key_word1,
   input  logic [WORD_W-1:0] req_key_word2,
   input  logic [WORD_W-1:0] req_key_word3,
   input  logic [WORD_W-1:0] req_key_word4,
   input  logic [WORD_W-1:0] req_key_word5,
   input  logic [ID_W-1:0]   req_rollback_mark,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_entry_id,
   output logic [2:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ID_W-1:0]   csr_max_entries
   );

   localparam int SB = $clog2(SLOT_COUNT);
   localparam int SE_W = ID_W + SB;
   localparam int WW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int KADDR_W = $clog2(ID_COUNT * KEY_WORDS);
   localparam int LOAD_LIMIT = (SLOT_COUNT * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;
   localparam int LL_W = $clog2(LOAD_LIMIT + 1) + 1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_GO,
      ST_HASH_WAIT,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_KEY_WR,
      ST_RB_CHECK,
      ST_RB_KRD,
      ST_RB_KCAP,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RB_FINISH
   } state_type;

   state_type      state_ff, state_in;
   logic [ID_W-1:0] count_ff, count_in;
   logic           sticky_ff, sticky_in;
   logic [ID_W-1:0] max_ff;
   logic           mode_ff, mode_in;
   logic [ID_W-1:0] mark_ff, mark_in;
   logic [SB-1:0]  pos_ff, pos_in;
   logic [SB-1:0]  scan_ff, scan_in;
   logic [SB-1:0]  n_ff, n_in;
   logic [SB-1:0]  home_ff, home_in;
   logic [SB-1:0]  clr_ff, clr_in;
   logic [ID_W-1:0] cand_ff, cand_in;
   logic [WW-1:0]  w_ff, w_in;
   logic [WORD_W-1:0] key_ff [KEY_WORDS];
   logic [WORD_W-1:0] key_in [KEY_WORDS];
   logic           rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   status_type     rsp_status_ff, rsp_status_in;

   logic [WORD_W-1:0] in_words [IN_KEY_FIELDS];
   logic [WORD_W-1:0] load_words [KEY_WORDS];

   logic           slot_we;
   logic [SB-1:0]  slot_waddr;
   logic [SE_W-1:0] slot_wdata;
   logic [SB-1:0]  slot_raddr;
   logic [SE_W-1:0] slot_rdata;
   logic [ID_W-1:0] rd_id;
   logic [SB-1:0]  rd_home;

   logic           key_we;
   logic [KADDR_W-1:0] key_waddr;
   logic [WORD_W-1:0] key_wdata;
   logic [KADDR_W-1:0] key_raddr;
   logic [WORD_W-1:0] key_rdata;

   logic           hash_start;
   logic [WW-1:0]  hash_widx;
   logic           hash_done;
   logic [SB-1:0]  hash_home;
   logic [WW-1:0]  key_rd_idx;
   logic [WORD_W-1:0] key_word_sel;

   logic [LL_W-1:0] load_next;
   logic           load_full;
   logic           limit_hit;
   logic           w_last;
   logic           n_last;
   logic [KADDR_W-1:0] count_base;
   logic [KADDR_W-1:0] cand_base;

   // Input key words, zero beyond the six carried on the ports
   assign in_words[0] = req_key_word0;
   assign in_words[1] = req_key_word1;
   assign in_words[2] = req_key_word2;
   assign in_words[3] = req_key_word3;
   assign in_words[4] = req_key_word4;
   assign in_words[5] = req_key_word5;

   for (genvar gi = 0; gi < KEY_WORDS; gi++) begin : g_load
      if (gi < IN_KEY_FIELDS) begin : g_port
         assign load_words[gi] = in_words[gi];
      end else begin : g_zero
         assign load_words[gi] = '0;
      end
   end

   // Slot table: {id, home} per slot
   hcit_ram #(.WIDTH(SE_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   // Key store: KEY_WORDS words per id
   hcit_ram #(.WIDTH(WORD_W), .DEPTH(ID_COUNT * KEY_WORDS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   // Shared hash engine
   hcit_hash #(.KEY_WORDS(KEY_WORDS), .SLOT_BITS(SB)) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .word     (key_word_sel),
      .word_idx (hash_widx),
      .done     (hash_done),
      .home     (hash_home)
   );

   // Shared helpers
   always_comb begin
      hash_start = (state_ff == ST_HASH_GO);
      key_rd_idx = (state_ff == ST_HASH_WAIT) ? hash_widx : w_ff;
      key_word_sel = key_ff[key_rd_idx];
      rd_id = slot_rdata[SE_W-1 -: ID_W];
      rd_home = slot_rdata[SB-1:0];
      load_next = LL_W'(count_ff) + LL_W'(1);
      load_full = (load_next >= LL_W'(LOAD_LIMIT));
      limit_hit = (count_ff >= ID_LIMIT) || ((max_ff != '0) && (count_ff >= max_ff));
      w_last = (w_ff == WW'(KEY_WORDS - 1));
      n_last = (n_ff == SB'(SLOT_COUNT - 1));
      count_base = KADDR_W'(count_ff * KEY_WORDS);
      cand_base = KADDR_W'(cand_ff * KEY_WORDS);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sticky_in = sticky_ff;
      mode_in = mode_ff;
      mark_in = mark_ff;
      pos_in = pos_ff;
      scan_in = scan_ff;
      n_in = n_ff;
      home_in = home_ff;
      clr_in = clr_ff;
      cand_in = cand_ff;
      w_in = w_ff;
      key_in = key_ff;
      rsp_valid_in = 1'b0;
      rsp_id_in = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      slot_we = 1'b0;
      slot_waddr = pos_ff;
      slot_wdata = '0;
      slot_raddr = pos_ff;
      key_we = 1'b0;
      key_waddr = count_base + KADDR_W'(w_ff);
      key_wdata = key_ff[w_ff];
      key_raddr = count_base + KADDR_W'(w_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            slot_we = 1'b1;
            slot_waddr = clr_ff;
            if (clr_ff == SB'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               mode_in = req_command;
               if (req_command == CMD_ROLLBACK) begin
                  mark_in = req_rollback_mark;
                  state_in = ST_RB_CHECK;
               end else if (sticky_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in = '0;
                  rsp_status_in = STS_REFUSED;
               end else if (load_full) begin
                  sticky_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_id_in = '0;
                  rsp_status_in = STS_FULL;
               end else begin
                  key_in = load_words;
                  state_in = ST_HASH_GO;
               end
            end
         end
         ST_HASH_GO: begin
            state_in = ST_HASH_WAIT;
         end
         ST_HASH_WAIT: begin
            if (hash_done) begin
               pos_in = hash_home;
               home_in = hash_home;
               n_in = '0;
               state_in = (mode_ff == CMD_ROLLBACK) ? ST_FIND_RD : ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            if (rd_id == '0) begin
               // Empty slot: insert unless a limit is hit
               if (limit_hit) begin
                  sticky_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_id_in = '0;
                  rsp_status_in = STS_LIMIT;
                  state_in = ST_IDLE;
               end else begin
                  slot_we = 1'b1;
                  slot_wdata = {count_ff + 1'b1, home_ff};
                  count_in = count_ff + 1'b1;
                  w_in = '0;
                  state_in = ST_KEY_WR;
               end
            end else if (rd_home == home_ff) begin
               cand_in = rd_id;
               w_in = '0;
               state_in = ST_CMP_RD;
            end else if (n_last) begin
               sticky_in = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_id_in = '0;
               rsp_status_in = STS_FULL;
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
               n_in = n_ff + 1'b1;
               state_in = ST_PROBE_RD;
            end
         end
         ST_CMP_RD: begin
            key_raddr = cand_base + KADDR_W'(w_ff);
            state_in = ST_CMP_CHK;
         end
         ST_CMP_CHK: begin
            if (key_rdata != key_ff[w_ff]) begin
               // Mismatch: move on to the next slot
               if (n_last) begin
                  sticky_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_id_in = '0;
                  rsp_status_in = STS_FULL;
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  n_in = n_ff + 1'b1;
                  state_in = ST_PROBE_RD;
               end
            end else if (w_last) begin
               rsp_valid_in = 1'b1;
               rsp_id_in = cand_ff;
               rsp_status_in = STS_FOUND;
               state_in = ST_IDLE;
            end else begin
               w_in = w_ff + 1'b1;
               state_in = ST_CMP_RD;
            end
         end
         ST_KEY_WR: begin
            key_we = 1'b1;
            if (w_last) begin
               rsp_valid_in = 1'b1;
               rsp_id_in = count_ff;
               rsp_status_in = STS_INSERTED;
               state_in = ST_IDLE;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         ST_RB_CHECK: begin
            if (count_ff > mark_ff) begin
               w_in = '0;
               state_in = ST_RB_KRD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_id_in = '0;
               rsp_status_in = STS_ROLLBACK;
               state_in = ST_IDLE;
            end
         end
         ST_RB_KRD: begin
            state_in = ST_RB_KCAP;
         end
         ST_RB_KCAP: begin
            // Reload the newest id's key to rebuild its home slot
            key_in[w_ff] = key_rdata;
            if (w_last) begin
               state_in = ST_HASH_GO;
            end else begin
               w_in = w_ff + 1'b1;
               state_in = ST_RB_KRD;
            end
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            if (rd_id == count_ff) begin
               scan_in = pos_ff + 1'b1;
               n_in = '0;
               state_in = ST_SCAN_RD;
            end else if (n_last) begin
               count_in = count_ff - 1'b1;
               state_in = ST_RB_CHECK;
            end else begin
               pos_in = pos_ff + 1'b1;
               n_in = n_ff + 1'b1;
               state_in = ST_FIND_RD;
            end
         end
         ST_SCAN_RD: begin
            slot_raddr = scan_ff;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (rd_id == '0) begin
               state_in = ST_RB_FINISH;
            end else begin
               // Backward shift: pull the entry into the hole if its home allows
               if ((scan_ff - rd_home) >= (scan_ff - pos_ff)) begin
                  slot_we = 1'b1;
                  slot_wdata = slot_rdata;
                  pos_in = scan_ff;
               end
               scan_in = scan_ff + 1'b1;
               if (n_last) begin
                  state_in = ST_RB_FINISH;
               end else begin
                  n_in = n_ff + 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_RB_FINISH: begin
            slot_we = 1'b1;
            count_in = count_ff - 1'b1;
            state_in = ST_RB_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         count_ff <= '0;
         sticky_ff <= 1'b0;
         max_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sticky_ff <= sticky_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_max_entries;
         end
      end
      mode_ff <= mode_in;
      mark_ff <= mark_in;
      pos_ff <= pos_in;
      scan_ff <= scan_in;
      n_ff <= n_in;
      home_ff <= home_in;
      cand_ff <= cand_in;
      w_ff <= w_in;
      key_ff <= key_in;
      rsp_id_ff <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry_id = rsp_id_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[src/hcit_checker.sv]
module hcit_checker
   import hcit_pkg::*;
   (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_valid,
   input logic [ID_W-1:0] rsp_entry_id,
   input logic [2:0]      rsp_status
   );

   // Status codes stay within the defined set
   a_sts_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_ROLLBACK)
      else $error("status code out of range");

   // The block is free again when it answers
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // Failures and rollback carry id zero
   a_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_LIMIT || rsp_status == STS_FULL ||
                    rsp_status == STS_REFUSED || rsp_status == STS_ROLLBACK)
      |-> rsp_entry_id == '0)
      else $error("nonzero id on failure or rollback");

   // Found and inserted ids are real ids
   a_real_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_FOUND || rsp_status == STS_INSERTED)
      |-> rsp_entry_id != '0)
      else $error("zero id on success");

   // No result without a transfer having started work
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result out of nowhere");

endmodule

bind hash_consing_intern_table_unit hcit_checker u_hcit_checker (.*);
